[rtl/core/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and helpers for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   // task table size, task 0 is the idle task
   localparam int NUM_TASKS = 5;
   localparam int TASK_W    = $clog2(NUM_TASKS);

   // fixed field widths of the channels
   localparam int MODE_W  = 2;
   localparam int TICK_W  = 32;
   localparam int CUR_W   = 3;
   localparam int MASK_W  = 5;

   // event codes on the request channel
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELAY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PICK  = 2'd2;

   typedef logic [TASK_W-1:0] task_idx_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TICK_W-1:0] delay_ticks;
   } rrts_cmd_type;

   typedef struct packed {
      logic [CUR_W-1:0]  current_task;
      logic [MASK_W-1:0] ready_mask;
      logic              switch_pending;
   } rrts_result_type;

   // next task index in round-robin order, wrapping to zero
   function automatic task_idx_type next_task(input task_idx_type idx);
      task_idx_type nxt;
      if (idx == task_idx_type'(NUM_TASKS - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + task_idx_type'(1);
      end
      return nxt;
   endfunction

   // running task index as reported on the result channel
   function automatic logic [CUR_W-1:0] to_current(input task_idx_type idx);
      logic [31:0] ext;
      ext = 32'(idx);
      return ext[CUR_W-1:0];
   endfunction

   // ready flags as reported on the result channel, absent tasks read zero
   function automatic logic [MASK_W-1:0] to_mask(input logic [NUM_TASKS-1:0] rdy);
      logic [31:0] ext;
      ext = 32'(rdy);
      return ext[MASK_W-1:0];
   endfunction

endpackage

[rtl/core/rrts_req_if.sv]
// ----------------------------------------------------------------------------
// rrts_req_if
// Request channel of the task scheduler: one scheduling event per beat.
// ----------------------------------------------------------------------------
interface rrts_req_if;
   logic                                valid;
   logic                                ready;
   logic [rrts_pkg::MODE_W-1:0]         mode;
   logic [rrts_pkg::TICK_W-1:0]         delay_ticks;

   modport source (output valid, output mode, output delay_ticks, input ready);
   modport sink   (input valid, input mode, input delay_ticks, output ready);
endinterface

[rtl/core/rrts_rsp_if.sv]
// ----------------------------------------------------------------------------
// rrts_rsp_if
// Response channel of the task scheduler: scheduler status per beat.
// ----------------------------------------------------------------------------
interface rrts_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rrts_pkg::CUR_W-1:0]          current_task;
   logic [rrts_pkg::MASK_W-1:0]         ready_mask;
   logic                                switch_pending;

   modport source (output valid, output current_task, output ready_mask,
                   output switch_pending, input ready);
   modport sink   (input valid, input current_task, input ready_mask,
                   input switch_pending, output ready);
endinterface

[rtl/core/round_robin_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Round-robin task scheduler with tick-based delay blocking.
// ----------------------------------------------------------------------------
// One request beat is one event: a timer tick, a delay of the running task or
// a pick of the next task; each event returns one response beat with the
// running task, the ready flags and the switch request. The block takes one
// event at a time. A delay or an unused code goes straight to the done state;
// a tick walks the wake-time table through its single read port, one task per
// cycle; a pick walks the candidate tasks, one per cycle, and stops at the
// first ready one. The response sits in an output register, so a stalled
// response does not hold the next request back until that request has its own
// result ready.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   rrts_req_if.sink    req_ch,
   rrts_rsp_if.source  rsp_ch
);

   logic                      start;
   logic                      take;
   logic                      eng_idle;
   logic                      eng_done;
   rrts_pkg::rrts_cmd_type    cmd;
   rrts_pkg::rrts_result_type eng_result;

   logic                      rsp_valid_ff, rsp_valid_in;
   rrts_pkg::rrts_result_type rsp_data_ff;

   // request side
   assign req_ch.ready    = eng_idle;
   assign start           = req_ch.valid && eng_idle;
   assign cmd.mode        = req_ch.mode;
   assign cmd.delay_ticks = req_ch.delay_ticks;

   // output register is free when empty or drained this cycle
   assign take = !rsp_valid_ff || rsp_ch.ready;

   rrts_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (cmd),
      .take   (take),
      .idle   (eng_idle),
      .done   (eng_done),
      .result (eng_result)
   );

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_done && take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (eng_done && take) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.current_task   = rsp_data_ff.current_task;
   assign rsp_ch.ready_mask     = rsp_data_ff.ready_mask;
   assign rsp_ch.switch_pending = rsp_data_ff.switch_pending;

endmodule

[rtl/core/rrts_engine.sv]
// ----------------------------------------------------------------------------
// rrts_engine
// Scheduler state and sequencer: walks the wake-time table on a tick and the
// ready flags on a pick, one task per cycle, with one adder and one compare.
// ----------------------------------------------------------------------------
module rrts_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rrts_pkg::rrts_cmd_type    cmd,
   input  logic                      take,
   output logic                      idle,
   output logic                      done,
   output rrts_pkg::rrts_result_type result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_PICK = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int N = rrts_pkg::NUM_TASKS;
   localparam int W = rrts_pkg::TICK_W;

   logic [1:0]                  state_ff, state_in;
   logic [W-1:0]                tick_ff, tick_in;
   rrts_pkg::task_idx_type      run_ff, run_in;
   logic [N-1:0]                ready_ff, ready_in;
   rrts_pkg::task_idx_type      idx_ff, idx_in;
   rrts_pkg::task_idx_type      steps_ff, steps_in;
   logic                        sw_ff, sw_in;

   // wake-time table read pipeline
   logic [W-1:0]                wake_mem [N];
   logic [W-1:0]                rd_data_ff;
   rrts_pkg::task_idx_type      cmp_idx_ff;
   logic                        cmp_vld_ff, cmp_vld_in;

   // shared adder: tick increment or wake-time computation
   logic [W-1:0]                add_b;
   logic [W-1:0]                add_sum;
   logic                        wake_hit;
   logic                        delay_wr;

   assign add_b    = (cmd.mode == rrts_pkg::MODE_DELAY) ? cmd.delay_ticks : W'(1);
   assign add_sum  = tick_ff + add_b;
   assign wake_hit = (rd_data_ff == tick_ff);
   assign delay_wr = start && (cmd.mode == rrts_pkg::MODE_DELAY) && (run_ff != '0);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      tick_in    = tick_ff;
      run_in     = run_ff;
      ready_in   = ready_ff;
      idx_in     = idx_ff;
      steps_in   = steps_ff;
      sw_in      = sw_ff;
      cmp_vld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sw_in    = 1'b0;
               state_in = ST_DONE;
               case (cmd.mode)
                  rrts_pkg::MODE_TICK: begin
                     tick_in  = add_sum;
                     idx_in   = rrts_pkg::task_idx_type'(1);
                     sw_in    = 1'b1;
                     state_in = ST_TICK;
                  end
                  rrts_pkg::MODE_DELAY: begin
                     if (run_ff != '0) begin
                        ready_in[run_ff] = 1'b0;
                        sw_in            = 1'b1;
                     end
                  end
                  rrts_pkg::MODE_PICK: begin
                     idx_in   = rrts_pkg::next_task(run_ff);
                     steps_in = '0;
                     state_in = ST_PICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            // issue one table read per cycle, compare it in the cycle after
            if (idx_ff != '0) begin
               cmp_vld_in = 1'b1;
               idx_in     = rrts_pkg::next_task(idx_ff);
            end
            if (cmp_vld_ff) begin
               if (!ready_ff[cmp_idx_ff] && wake_hit) begin
                  ready_in[cmp_idx_ff] = 1'b1;
               end
               if (cmp_idx_ff == rrts_pkg::task_idx_type'(N - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PICK: begin
            // one candidate per cycle, current task checked last
            if ((idx_ff != '0) && ready_ff[idx_ff]) begin
               run_in   = idx_ff;
               state_in = ST_DONE;
            end else if (steps_ff == rrts_pkg::task_idx_type'(N - 1)) begin
               run_in   = '0;
               state_in = ST_DONE;
            end else begin
               idx_in   = rrts_pkg::next_task(idx_ff);
               steps_in = steps_ff + rrts_pkg::task_idx_type'(1);
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tick_ff    <= '0;
         run_ff     <= rrts_pkg::task_idx_type'(1);
         ready_ff   <= '1;
         idx_ff     <= '0;
         steps_ff   <= '0;
         sw_ff      <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tick_ff    <= tick_in;
         run_ff     <= run_in;
         ready_ff   <= ready_in;
         idx_ff     <= idx_in;
         steps_ff   <= steps_in;
         sw_ff      <= sw_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // wake-time table write port
   always_ff @(posedge clock) begin
      if (delay_wr) begin
         wake_mem[run_ff] <= add_sum;
      end
   end

   // wake-time table read port
   always_ff @(posedge clock) begin
      rd_data_ff <= wake_mem[idx_ff];
      cmp_idx_ff <= idx_ff;
   end

   assign idle = (state_ff == ST_IDLE);
   assign done = (state_ff == ST_DONE);

   assign result.current_task   = rrts_pkg::to_current(run_ff);
   assign result.ready_mask     = rrts_pkg::to_mask(ready_ff);
   assign result.switch_pending = sw_ff;

`ifndef NO_ASSERTIONS
   // the idle task never blocks
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      ready_ff[0])
      else $error("idle task lost its ready flag");

   // running task index stays within the table
   a_run_range: assert property (@(posedge clock) disable iff (reset)
      run_ff <= rrts_pkg::task_idx_type'(N - 1))
      else $error("running task out of range");

   // a delay blocks the running user task
   a_delay_blocks: assert property (@(posedge clock) disable iff (reset)
      delay_wr |=> !ready_ff[$past(run_ff)] && (state_ff == ST_DONE))
      else $error("delay did not block the running task");

   // a finished result holds until the output side takes it
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && !take |=> (state_ff == ST_DONE) && $stable(run_ff)
         && $stable(ready_ff))
      else $error("result changed before hand-off");

   // pick walk never runs past the whole table
   a_pick_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> steps_ff <= rrts_pkg::task_idx_type'(N - 1))
      else $error("pick walk overran the task table");
`endif

endmodule
